>>> src/mts_pkg.sv
// shared constants and types for the min tracking stack
// depends on nothing; used by every module of the block
package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 11;
  localparam int KIND_W      = 2;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // shift command for one row of cells
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

>>> src/mts_cell.sv
// one stack cell: holds a value and shifts it to or from its neighbors
// depends on mts_pkg
module mts_cell (
  input  logic                           clk_i,
  input  mts_pkg::shift_ctrl_t           ctrl_i,
  input  logic [mts_pkg::DATA_W-1:0]     above_i,
  input  logic [mts_pkg::DATA_W-1:0]     below_i,
  output logic [mts_pkg::DATA_W-1:0]     value_o
);

  logic [mts_pkg::DATA_W-1:0] value_q;
  logic [mts_pkg::DATA_W-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.push) begin
      value_d = above_i;
    end else if (ctrl_i.pop) begin
      value_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> src/mts_chain.sv
// row of stack cells; cell 0 is the top of the stack
// depends on mts_pkg and mts_cell
module mts_chain (
  input  logic                           clk_i,
  input  mts_pkg::shift_ctrl_t           ctrl_i,
  input  logic [mts_pkg::DATA_W-1:0]     push_data_i,
  output logic [mts_pkg::DATA_W-1:0]     top_o,
  output logic [mts_pkg::DATA_W-1:0]     next_o
);

  logic [mts_pkg::DATA_W-1:0] cell_val [mts_pkg::STACK_DEPTH];

  for (genvar i = 0; i < mts_pkg::STACK_DEPTH; i++) begin : g_cell
    logic [mts_pkg::DATA_W-1:0] above;
    logic [mts_pkg::DATA_W-1:0] below;

    if (i == 0) begin : g_top
      assign above = push_data_i;
    end else begin : g_mid
      assign above = cell_val[i-1];
    end

    // bottom cell refills with zero on a pop
    if (i == mts_pkg::STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_val[i+1];
    end

    mts_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .above_i (above),
      .below_i (below),
      .value_o (cell_val[i])
    );
  end

  assign top_o  = cell_val[0];
  assign next_o = cell_val[1];

endmodule

>>> src/min_tracking_stack_core.sv
// top level of the min tracking stack
// depends on mts_pkg, mts_chain and mts_cell
//
// A LIFO of signed 32-bit values that reports its running minimum with every item.
// Values live in a row of shift cells (push shifts the row down, pop shifts it up),
// and a second row of cells holds the stack of minima, so every operation touches
// only the tops and two counters. One item is accepted per clock cycle; its result
// appears in the output register in the cycle after acceptance and the block keeps
// accepting while that register is empty or being taken in the same cycle.
// There is no clearing pass after reset: cells below the entry count are never read.
// capacity_limit may be written through the config channel while the block is idle;
// a limit above the stack depth acts as the depth, and a limit of zero rejects all pushes.
module min_tracking_stack_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mts_pkg::CAP_W-1:0]             cfg_capacity_limit_i,
  // item input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [mts_pkg::KIND_W-1:0]            kind_i,
  input  logic signed [mts_pkg::DATA_W-1:0]     push_value_i,
  // result output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [mts_pkg::DATA_W-1:0]     popped_value_o,
  output logic signed [mts_pkg::DATA_W-1:0]     current_minimum_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o,
  output logic [1:0]                            status_o
);

  // config register
  logic [mts_pkg::CAP_W-1:0] cap_q;

  // counters
  logic [mts_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [mts_pkg::CNT_W-1:0] mcnt_q, mcnt_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [mts_pkg::DATA_W-1:0]  popped_q, popped_d;
  logic [mts_pkg::DATA_W-1:0]  minimum_q, minimum_d;
  logic                        empty_q, empty_d;
  logic                        full_q, full_d;
  mts_pkg::status_e            status_q, status_d;

  // chain tops
  logic [mts_pkg::DATA_W-1:0] val_top;
  logic [mts_pkg::DATA_W-1:0] min_top;
  logic [mts_pkg::DATA_W-1:0] min_next;
  logic [mts_pkg::DATA_W-1:0] new_min;

  logic [mts_pkg::LIM_W-1:0] cap_ext;
  logic [mts_pkg::LIM_W-1:0] limit;
  logic                      fire;
  logic                      is_push, is_pop;
  logic                      push_ok, pop_ok;
  logic                      min_push, min_pop;

  mts_pkg::shift_ctrl_t val_ctrl;
  mts_pkg::shift_ctrl_t min_ctrl;

  assign cfg_ready_o = 1'b1;

  // accept while the output register is free or drains this cycle
  assign in_stall_o = out_valid_q & out_stall_i;
  assign fire       = in_valid_i & ~in_stall_o;

  // limit saturates at the stack depth
  assign cap_ext = mts_pkg::LIM_W'(cap_q);
  assign limit   = (cap_ext > mts_pkg::LIM_W'(mts_pkg::STACK_DEPTH))
                 ? mts_pkg::LIM_W'(mts_pkg::STACK_DEPTH) : cap_ext;

  // kinds 2 and 3 fall through to a status read
  assign is_push = (kind_i == mts_pkg::KIND_PUSH);
  assign is_pop  = (kind_i == mts_pkg::KIND_POP);

  always_comb begin
    push_ok  = is_push && (mts_pkg::LIM_W'(cnt_q) < limit);
    pop_ok   = is_pop && (cnt_q != '0);

    // the minimum row takes a push when empty or on a tie or new low
    min_push = push_ok
            && ((mcnt_q == '0) || ($signed(push_value_i) <= $signed(min_top)))
            && (mcnt_q < mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));
    // it pops when the value leaving is its own top
    min_pop  = pop_ok && (mcnt_q != '0) && (min_top == val_top);

    cnt_d  = cnt_q;
    mcnt_d = mcnt_q;
    if (push_ok) begin
      cnt_d = cnt_q + mts_pkg::CNT_W'(1);
    end else if (pop_ok) begin
      cnt_d = cnt_q - mts_pkg::CNT_W'(1);
    end
    if (min_push) begin
      mcnt_d = mcnt_q + mts_pkg::CNT_W'(1);
    end else if (min_pop) begin
      mcnt_d = mcnt_q - mts_pkg::CNT_W'(1);
    end

    // minimum row top after this item
    if (min_push) begin
      new_min = push_value_i;
    end else if (min_pop) begin
      new_min = min_next;
    end else begin
      new_min = min_top;
    end

    popped_d  = pop_ok ? val_top : '0;
    minimum_d = ((cnt_d != '0) && (mcnt_d != '0)) ? new_min : '0;
    empty_d   = (cnt_d == '0);
    full_d    = (mts_pkg::LIM_W'(cnt_d) >= limit);

    if (is_push && !push_ok) begin
      status_d = mts_pkg::STATUS_FULL;
    end else if (is_pop && !pop_ok) begin
      status_d = mts_pkg::STATUS_EMPTY;
    end else begin
      status_d = mts_pkg::STATUS_OK;
    end

    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign val_ctrl.push = fire & push_ok;
  assign val_ctrl.pop  = fire & pop_ok;
  assign min_ctrl.push = fire & min_push;
  assign min_ctrl.pop  = fire & min_pop;

  // value row
  mts_chain u_val_chain (
    .clk_i       (clk_i),
    .ctrl_i      (val_ctrl),
    .push_data_i (push_value_i),
    .top_o       (val_top),
    .next_o      ()
  );

  // running minimum row
  mts_chain u_min_chain (
    .clk_i       (clk_i),
    .ctrl_i      (min_ctrl),
    .push_data_i (push_value_i),
    .top_o       (min_top),
    .next_o      (min_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= mts_pkg::CAP_RESET;
      cnt_q       <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_capacity_limit_i;
      end
      if (fire) begin
        cnt_q  <= cnt_d;
        mcnt_q <= mcnt_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on accept
  always_ff @(posedge clk_i) begin
    if (fire) begin
      popped_q  <= popped_d;
      minimum_q <= minimum_d;
      empty_q   <= empty_d;
      full_q    <= full_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign popped_value_o    = popped_q;
  assign current_minimum_o = minimum_q;
  assign is_empty_o        = empty_q;
  assign is_full_o         = full_q;
  assign status_o          = status_q;

endmodule

>>> src/mts_checker.sv
// port level checks for the min tracking stack
// depends on mts_pkg; bound to min_tracking_stack_core
module mts_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [mts_pkg::DATA_W-1:0]        popped_value_o,
  input logic [mts_pkg::DATA_W-1:0]        current_minimum_o,
  input logic                              is_empty_o,
  input logic                              is_full_o,
  input logic [1:0]                        status_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(popped_value_o)
      && $stable(current_minimum_o) && $stable(status_o))
    else $error("result changed while stalled");

  // every accepted item yields a result next cycle
  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // empty stack has no minimum
  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> current_minimum_o == '0)
    else $error("minimum nonzero on empty stack");

  // rejected push only when full, and nothing popped
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mts_pkg::STATUS_FULL |-> is_full_o && popped_value_o == '0)
    else $error("push rejected while not full");

  // rejected pop only when empty, and nothing popped
  a_empty_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mts_pkg::STATUS_EMPTY |-> is_empty_o && popped_value_o == '0)
    else $error("pop rejected while not empty");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .popped_value_o    (popped_value_o),
  .current_minimum_o (current_minimum_o),
  .is_empty_o        (is_empty_o),
  .is_full_o         (is_full_o),
  .status_o          (status_o)
);
